// ===== hdl/ecgf_pkg.sv =====
package ecgf_pkg;

  // field widths
  localparam int IDX_W  = 16;
  localparam int ELEV_W = 24;
  localparam int VAR_W  = 24;

  // gain is Q0.16 plus one integer bit so that exactly 1.0 fits
  localparam int FRAC_W = 16;
  localparam int GAIN_W = FRAC_W + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 56;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_ADDR,
    ST_LOOKUP,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_FINISH
  } fuse_state_t;

  typedef struct packed {
    logic                     occupied;
    logic [VAR_W-1:0]         variance;
    logic signed [ELEV_W-1:0] mean;
  } cell_entry_t;

  // handshake between sequencer and gain divider
  typedef struct packed {
    logic                start;
    logic [VAR_W-1:0]    cell_var;
    logic [VAR_W:0]      var_sum;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [GAIN_W-1:0]   gain;
  } div_rsp_t;

endpackage

// ===== hdl/ecgf_gain_div.sv =====
// Restoring divider: gain = floor(v * 2^16 / (v + pv)), one quotient bit a cycle.
// The quotient never exceeds 2^16, so only the last GAIN_W dividend bits are walked;
// the bits above them (v >> 1) already sit below the divisor.
module ecgf_gain_div
  import ecgf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(GAIN_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] step_cnt;
  logic [VAR_W:0]   rem;
  logic [VAR_W:0]   divisor;
  logic             next_bit;
  logic [GAIN_W-1:0] quot;

  logic [VAR_W+1:0] trial;
  logic [VAR_W+1:0] trial_sub;
  logic             fits;

  assign trial     = {rem, next_bit};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        step_cnt <= CNT_W'(GAIN_W - 1);
      end else if (busy) begin
        if (step_cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step_cnt <= step_cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= {2'b00, req.cell_var[VAR_W-1:1]};
      next_bit <= req.cell_var[0];
      divisor  <= req.var_sum;
      quot     <= '0;
    end else if (busy) begin
      rem      <= fits ? trial_sub[VAR_W:0] : trial[VAR_W:0];
      next_bit <= 1'b0;
      quot     <= {quot[GAIN_W-2:0], fits};
    end
  end

  assign rsp = '{done: done, gain: quot};

endmodule

// ===== hdl/elevation_cell_gaussian_fusion_unit.sv =====
// Elevation cell Gaussian fusion.
//
// Input stream (s_axis_*): one transaction per measured point, carrying the
// grid cell index, the point elevation (Q11.12 m) and its variance (Q4.20 m^2).
// Output stream (m_axis_*): one transaction per point with the cell's fused
// mean, fused variance and a first-write flag.
//
// Cell state (occupied flag, mean, variance) lives in one single-port-write,
// registered-read memory of CELL_COUNT words. Each point is a read-modify-write
// of its cell; one point is in flight at a time, which serves as the interlock
// for repeated hits on the same cell. Indices at or above CELL_COUNT wrap.
// A point passes through the sequencer states REDUCE, ADDR and LOOKUP; an empty
// cell then goes straight to FINISH, while an occupied cell goes through MUL and
// ADD first, preceded by DIV on the bit-serial gain divider (17 quotient bits, one
// per cycle) unless both variances are zero. The next point is taken the cycle
// after write-back, even if its result still waits in the output register. If the
// receiver stalls, the finished point holds in the sequencer until the output
// register frees.
// Reset: a clearing pass marks every cell empty, one word a cycle; s_axis_tready
// stays low until it ends.
module elevation_cell_gaussian_fusion_unit
  import ecgf_pkg::*;
#(
  parameter int CELL_COUNT = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // cell_index[15:0], point_elevation[39:16], point_variance[63:40]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // fused_mean[23:0], fused_variance[47:24], first_write[48], zero pad[55:49]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  // index wrap only matters when the map is smaller than the index range
  localparam bit WRAP = CELL_COUNT < (1 << IDX_W);
  // reciprocal for index / CELL_COUNT; exact for 16-bit indices with a 32-bit shift
  localparam int RECIP_SHIFT = 32;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SHIFT) + longint'(CELL_COUNT) - 1) / longint'(CELL_COUNT);
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int RP_W    = IDX_W + RECIP_W;
  localparam int PM_W    = ELEV_W + 1 + GAIN_W + 1;
  localparam int PV_W    = VAR_W + GAIN_W;
  localparam int PAD_W   = M_TDATA_W - ELEV_W - VAR_W - 1;

  fuse_state_t state, state_next;

  // input fields
  logic [IDX_W-1:0]         cell_index;
  logic signed [ELEV_W-1:0] point_elevation;
  logic [VAR_W-1:0]         point_variance;

  assign cell_index      = s_axis_tdata[IDX_W-1:0];
  assign point_elevation = s_axis_tdata[IDX_W +: ELEV_W];
  assign point_variance  = s_axis_tdata[IDX_W+ELEV_W +: VAR_W];

  // captured point
  logic [IDX_W-1:0]         idx_q;
  logic signed [ELEV_W-1:0] z_q;
  logic [VAR_W-1:0]         pv_q;

  // index wrap
  logic [RP_W-1:0]  recip_prod;
  logic [IDX_W-1:0] quo;
  logic [IDX_W-1:0] wrap_prod;
  logic [IDX_W-1:0] cell_sel;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cell_addr;

  assign recip_prod = RP_W'(idx_q) * RP_W'(RECIP);
  assign wrap_prod  = IDX_W'(32'(quo) * 32'(CELL_COUNT));
  assign cell_sel   = WRAP ? (idx_q - wrap_prod) : idx_q;
  assign rd_addr    = ADDR_W'(cell_sel);

  // cell memory
  cell_entry_t cell_mem [CELL_COUNT];
  cell_entry_t rd_entry;
  cell_entry_t wr_entry;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] clr_addr;

  // fusion datapath
  logic signed [ELEV_W-1:0] m_q;
  logic [VAR_W-1:0]         v_q;
  logic [VAR_W:0]           var_sum;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [ELEV_W:0]   innov;
  logic signed [PM_W-1:0]   prod_mean;
  logic [PV_W-1:0]          prod_var;
  logic signed [ELEV_W-1:0] res_mean;
  logic [VAR_W-1:0]         res_var;
  logic                     res_first;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // output register
  logic                     out_load;
  logic signed [ELEV_W-1:0] out_mean;
  logic [VAR_W-1:0]         out_var;
  logic                     out_first;

  assign var_sum = {1'b0, rd_entry.variance} + {1'b0, pv_q};
  assign innov   = {z_q[ELEV_W-1], z_q} - {m_q[ELEV_W-1], m_q};

  assign s_axis_tready = (state == ST_IDLE);
  assign out_load      = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  assign div_req = '{start:    (state == ST_LOOKUP) && rd_entry.occupied && (var_sum != '0),
                     cell_var: rd_entry.variance,
                     var_sum:  var_sum};

  ecgf_gain_div u_gain_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(CELL_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_REDUCE;
      end
      ST_REDUCE: state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        if (!rd_entry.occupied) begin
          state_next = ST_FINISH;
        end else if (div_req.start) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // memory: one write port, one registered read port
  assign mem_we  = (state == ST_CLEAR) || out_load;
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : cell_addr;

  always_comb begin
    wr_entry = '0;
    if (state != ST_CLEAR) begin
      wr_entry.occupied = 1'b1;
      wr_entry.variance = res_var;
      wr_entry.mean     = res_mean;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[wr_addr] <= wr_entry;
    if (state == ST_ADDR) rd_entry <= cell_mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      idx_q <= cell_index;
      z_q   <= point_elevation;
      pv_q  <= point_variance;
    end
    if (state == ST_REDUCE) quo <= IDX_W'(recip_prod >> RECIP_SHIFT);
    if (state == ST_ADDR) cell_addr <= rd_addr;
    if (state == ST_LOOKUP) begin
      m_q    <= rd_entry.mean;
      v_q    <= rd_entry.variance;
      gain_q <= '0;
      if (!rd_entry.occupied) begin
        res_mean  <= z_q;
        res_var   <= pv_q;
        res_first <= 1'b1;
      end else begin
        res_first <= 1'b0;
      end
    end
    if (state == ST_DIV && div_rsp.done) gain_q <= div_rsp.gain;
    if (state == ST_MUL) begin
      prod_mean <= PM_W'(innov) * PM_W'($signed({1'b0, gain_q}));
      prod_var  <= PV_W'(v_q) * PV_W'(GAIN_ONE - gain_q);
    end
    if (state == ST_ADD) begin
      // arithmetic shift gives floor rounding of the correction
      res_mean <= ELEV_W'(PM_W'(m_q) + (prod_mean >>> FRAC_W));
      res_var  <= prod_var[FRAC_W +: VAR_W];
    end
    if (out_load) begin
      out_mean  <= res_mean;
      out_var   <= res_var;
      out_first <= res_first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_first, out_var, out_mean};

  // checks
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!s_axis_tready && !m_axis_tvalid))
    else $error("traffic during clearing pass");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second point taken while a cell update is open");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (div_rsp.gain <= GAIN_ONE))
    else $error("gain above one");

  a_var_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !res_first) |-> (res_var <= v_q))
    else $error("fused variance grew");

endmodule

// ===== bench/ecgf_fusion_checker.sv =====
module ecgf_fusion_checker
  import ecgf_pkg::*;
#(
  parameter int CELL_COUNT = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  // cell_index[15:0], point_elevation[39:16], point_variance[63:40]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // fused_mean[23:0], fused_variance[47:24], first_write[48], zero pad[55:49]
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  output int                   mismatches,
  output int                   awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNITY      = longint'(GAIN_ONE);
  localparam int     REPORT_CAP = 100;

  typedef struct packed {
    logic                     first_write;
    logic [VAR_W-1:0]         variance;
    logic signed [ELEV_W-1:0] mean;
  } fused_cell_t;

  // shadow copy of the cell store
  bit                       cell_seen   [CELL_COUNT];
  logic signed [ELEV_W-1:0] cell_height [CELL_COUNT];
  logic [VAR_W-1:0]         cell_spread [CELL_COUNT];

  fused_cell_t fused_q [$];
  int          errors = 0;

  // scalar Kalman update of one cell, updates the shadow store
  function automatic fused_cell_t fuse_point(logic [IDX_W-1:0] idx,
                                             logic signed [ELEV_W-1:0] z,
                                             logic [VAR_W-1:0] pv);
    int unsigned slot;
    longint      v, m, innov, gain, sum;
    fused_cell_t r;
    slot = idx % CELL_COUNT;
    if (!cell_seen[slot]) begin
      r.mean        = z;
      r.variance    = pv;
      r.first_write = 1'b1;
    end else begin
      v     = cell_spread[slot];
      m     = cell_height[slot];
      sum   = v + longint'(pv);
      gain  = 0;
      // both variances zero leaves the gain at zero
      if (sum != 0) gain = (v << FRAC_W) / sum;
      if (gain > UNITY) gain = UNITY;
      innov = longint'(z) - m;
      // arithmetic shift gives floor rounding on negative innovations
      r.mean        = ELEV_W'(m + ((innov * gain) >>> FRAC_W));
      r.variance    = VAR_W'((v * (UNITY - gain)) >>> FRAC_W);
      r.first_write = 1'b0;
    end
    cell_seen[slot]   = 1'b1;
    cell_height[slot] = r.mean;
    cell_spread[slot] = r.variance;
    return r;
  endfunction

  task automatic report(string field, longint want, longint got);
    errors++;
    if (errors <= REPORT_CAP)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    fused_cell_t want, got;
    if (rst) begin
      foreach (cell_seen[i]) cell_seen[i] = 1'b0;
      fused_q.delete();
    end else begin
      // retire the result first so a same-edge input lands behind it
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[ELEV_W+VAR_W:0];
        if (fused_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t ns: result transaction with nothing expected, actual mean %0d",
                     $time, got.mean);
        end else begin
          want = fused_q.pop_front();
          if (got.mean !== want.mean) report("fused_mean", want.mean, got.mean);
          if (got.variance !== want.variance)
            report("fused_variance", want.variance, got.variance);
          if (got.first_write !== want.first_write)
            report("first_write", want.first_write, got.first_write);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        fused_q.push_back(fuse_point(s_axis_tdata[IDX_W-1:0],
                                     s_axis_tdata[IDX_W +: ELEV_W],
                                     s_axis_tdata[IDX_W+ELEV_W +: VAR_W]));
    end
    mismatches <= errors;
    awaiting   <= fused_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ecgf_pkg::*;

  localparam int MAP_CELLS = 65536;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  int                   mismatches;
  int                   awaiting;

  // per-phase switches that turn idling off on either side
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;

  // a handful of cells that get hit again and again so fusion dominates
  logic [IDX_W-1:0] hot_cells [16];

  elevation_cell_gaussian_fusion_unit #(.CELL_COUNT(MAP_CELLS)) uut (.*);

  ecgf_fusion_checker #(.CELL_COUNT(MAP_CELLS)) checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // run guard: clearing pass plus every point with worst stalls, several times over
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output side back-pressure
  initial begin : sink
    int stall, run;
    @(negedge rst);
    forever begin
      stall = sink_calm ? 0 : idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // one point transaction; returns at the accepting edge with tvalid still high
  task automatic send_point(input logic [IDX_W-1:0] slot,
                            input logic signed [ELEV_W-1:0] z,
                            input logic [VAR_W-1:0] pv);
    int gap;
    gap = src_calm ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pv, z, slot};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // hold the source until every fused result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic random_points(input int count);
    int               r;
    logic [IDX_W-1:0] slot;
    logic [ELEV_W-1:0] z;
    logic [VAR_W-1:0] pv;
    repeat (count) begin
      r    = $urandom_range(99);
      slot = (r < 65) ? hot_cells[$urandom_range(15)] : IDX_W'($urandom_range(0, 65535));

      r = $urandom_range(99);
      if (r < 10) z = 24'h7FFFFF;
      else if (r < 20) z = 24'h800000;
      else if (r < 50) z = ELEV_W'($urandom_range(0, 8191) - 4096);
      else z = ELEV_W'($urandom());

      // zero variance drives the exact-unity and both-zero gain paths
      r = $urandom_range(99);
      if (r < 12) pv = '0;
      else if (r < 20) pv = 24'hFFFFFF;
      else if (r < 50) pv = VAR_W'($urandom_range(0, 1023));
      else if (r < 70) pv = VAR_W'($urandom_range(1, 65535));
      else pv = VAR_W'($urandom());

      send_point(slot, z, pv);
    end
  endtask

  initial begin : stimulus
    hot_cells[0] = '0;
    hot_cells[1] = '1;
    for (int i = 2; i < 16; i++) hot_cells[i] = IDX_W'($urandom());

    wait (!rst);
    @(posedge clk);

    // directed: field extremes, first writes, unity gain, both variances zero
    send_point(16'h0000, 24'h7FFFFF, 24'hFFFFFF);  // empty cell takes point
    send_point(16'h0000, 24'h800000, 24'hFFFFFF);  // half gain, full-scale drop
    send_point(16'h0000, 24'h7FFFFF, 24'hFFFFFF);
    send_point(16'hFFFF, 24'h800000, 24'h000000);  // first write with zero variance
    send_point(16'hFFFF, 24'h7FFFFF, 24'h000000);  // both zero, cell holds
    send_point(16'hFFFF, 24'h000000, 24'hFFFFFF);  // cell exact, gain zero
    send_point(16'h0001, 24'hFFFFFF, 24'h000001);
    send_point(16'h0001, 24'h7FFFFF, 24'h000000);  // point exact, gain one
    send_point(16'h0002, 24'h003039, 24'h100000);
    send_point(16'h0002, 24'hFFF000, 24'h000001);  // near-unity gain
    send_point(16'h0002, 24'h001000, 24'hFFFFFF);  // gain floors to zero
    send_point(16'h0002, 24'hFFF001, 24'h000003);
    send_point(16'h5555, 24'h555555, 24'hAAAAAA);
    send_point(16'hAAAA, 24'hAAAAAA, 24'h555555);
    send_point(16'h5555, 24'hAAAAAA, 24'h555555);
    send_point(16'hAAAA, 24'h555555, 24'hAAAAAA);
    send_point(16'h0003, 24'h000000, 24'h000000);
    send_point(16'h0003, 24'h000001, 24'h000000);  // both zero again
    drain();

    // phase 1: idling on both sides
    random_points(150);
    drain();

    // phase 2: back-to-back, no idling anywhere
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    random_points(150);
    drain();

    // phase 3: source streams, sink stalls
    sink_calm = 1'b0;
    random_points(150);
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && awaiting == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
